// ===== src/lc2k_pkg.sv =====
// ----------------------------------------------------------------------------
// lc2k_pkg
// Shared widths, field positions, codes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package lc2k_pkg;

  localparam int unsigned MEM_DEPTH_DEF = 65536;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned ITEM_ADDR_W   = 16;
  // signed width that holds every address expression before wrapping
  localparam int unsigned WOP_W         = 33;

  // instruction word fields
  localparam int unsigned OPC_LSB = 22;
  localparam int unsigned RA_LSB  = 19;
  localparam int unsigned RB_LSB  = 16;
  localparam int unsigned ILL_LSB = 25;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned REG_W   = 3;

  typedef enum logic [1:0] {
    ITEM_WRITE    = 2'd0,
    ITEM_EXEC     = 2'd1,
    ITEM_READ_MEM = 2'd2,
    ITEM_READ_REG = 2'd3
  } item_op_e;

  typedef enum logic [2:0] {
    INSTR_ADD  = 3'd0,
    INSTR_NOR  = 3'd1,
    INSTR_LW   = 3'd2,
    INSTR_SW   = 3'd3,
    INSTR_BEQ  = 3'd4,
    INSTR_JALR = 3'd5,
    INSTR_HALT = 3'd6,
    INSTR_NOOP = 3'd7
  } instr_op_e;

  typedef enum logic [1:0] {
    RUN_OK      = 2'd0,
    RUN_HALTED  = 2'd1,
    RUN_ILLEGAL = 2'd2
  } run_status_e;

  typedef struct packed {
    logic load_item;
    logic mem_rd;
    logic mem_wr;
    logic mem_at_pc;
    logic instr_load;
    logic wrap_start;
    logic reg_wr;
    logic mem_wb;
    logic pc_adv;
    logic pc_wrap;
    logic count_inc;
    logic set_halt;
    logic set_illegal;
  } dp_cmd_t;

  typedef struct packed {
    item_op_e  item_op;
    instr_op_e instr_op;
    logic      stopped;
    logic      illegal;
    logic      equal;
    logic      wrap_done;
  } dp_status_t;

endpackage

// ===== src/lc2k_wrap.sv =====
// ----------------------------------------------------------------------------
// lc2k_wrap
// Reduces a signed address expression modulo the memory depth.
// ----------------------------------------------------------------------------
module lc2k_wrap import lc2k_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [WOP_W-1:0]       operand_i,
  output logic                          done_o,
  output logic [$clog2(MEM_DEPTH)-1:0]  result_o
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  logic          done_q;
  logic [AW-1:0] res_q;

  if (MEM_DEPTH == (1 << AW)) begin : g_pow2
    // power-of-two depth: the low bits are the true modulus
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        res_q <= operand_i[AW-1:0];
      end
    end
  end else begin : g_iter
    localparam int unsigned MAG_W     = WORD_W;
    localparam int unsigned STEP_BITS = 4;
    localparam int unsigned NSTEPS    = MAG_W / STEP_BITS;
    localparam int unsigned CNT_W     = $clog2(NSTEPS + 1);
    localparam logic [AW:0] DIV       = (AW+1)'(MEM_DEPTH);

    logic              busy_q;
    logic [CNT_W-1:0]  cnt_q;
    logic              neg_q;
    logic [MAG_W-1:0]  mag_q;
    logic [AW-1:0]     rem_q;
    logic [AW-1:0]     rem_step;
    logic [AW-1:0]     fold;
    logic [WOP_W-1:0]  opd_abs;

    assign opd_abs = operand_i[WOP_W-1] ? WOP_W'(-operand_i) : WOP_W'(operand_i);

    // restoring reduction, STEP_BITS magnitude bits per cycle
    always_comb begin
      logic [AW:0] r;
      r = {1'b0, rem_q};
      for (int i = 0; i < STEP_BITS; i++) begin
        r = {r[AW-1:0], mag_q[MAG_W-1-i]};
        if (r >= DIV) begin
          r = r - DIV;
        end
      end
      rem_step = r[AW-1:0];
    end

    // negative operands wrap up from the top
    assign fold = (neg_q && (rem_q != '0)) ? AW'(DIV - {1'b0, rem_q}) : rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
        done_q <= 1'b0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(NSTEPS);
        end else if (busy_q) begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
          end else begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        neg_q <= operand_i[WOP_W-1];
        mag_q <= opd_abs[MAG_W-1:0];
        rem_q <= '0;
      end else if (busy_q && (cnt_q != '0)) begin
        rem_q <= rem_step;
        mag_q <= mag_q << STEP_BITS;
      end else if (busy_q) begin
        res_q <= fold;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== src/lc2k_datapath.sv =====
// ----------------------------------------------------------------------------
// lc2k_datapath
// Program counter, register file, main memory, status and the executed-instruction count.
// ----------------------------------------------------------------------------
module lc2k_datapath import lc2k_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  item_op_e                opcode_i,
  input  logic [ITEM_ADDR_W-1:0]  address_i,
  input  logic [WORD_W-1:0]       data_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  output logic [WORD_W-1:0]       read_data_o,
  output logic [ITEM_ADDR_W-1:0]  program_counter_o,
  output run_status_e             run_status_o,
  output logic [WORD_W-1:0]       executed_count_o
);

  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);
  localparam int unsigned NREGS     = 1 << REG_W;

  // item and instruction payload
  item_op_e                item_op_q;
  logic [ITEM_ADDR_W-1:0]  item_addr_q;
  logic [WORD_W-1:0]       item_data_q;
  logic [WORD_W-1:0]       instr_q;
  logic [WORD_W-1:0]       opa_q;
  logic [WORD_W-1:0]       opb_q;
  logic [WORD_W-1:0]       rdata_q;

  // architectural state
  logic [AW-1:0]           pc_q;
  run_status_e             status_q;
  logic [WORD_W-1:0]       count_q;
  logic [WORD_W-1:0]       rf_q [NREGS];
  logic [NREGS-1:0]        rf_valid_q;
  logic [WORD_W-1:0]       mem_q [MEM_DEPTH];
  logic [WORD_W-1:0]       mem_rdata_q;

  instr_op_e               instr_op;
  logic [REG_W-1:0]        ra_w;
  logic [REG_W-1:0]        rb_w;
  logic [REG_W-1:0]        rd_w;
  logic [WOP_W-1:0]        off_ext;
  logic [AW-1:0]           pc_next;
  logic signed [WOP_W-1:0] wrap_opd;
  logic [AW-1:0]           wrap_res;
  logic                    wrap_done;
  logic [AW-1:0]           mem_addr;
  logic [WORD_W-1:0]       mem_wdata;
  logic [REG_W-1:0]        rf_ra;
  logic [REG_W-1:0]        rf_rb;
  logic [WORD_W-1:0]       rf_a;
  logic [WORD_W-1:0]       rf_b;
  logic                    rf_we;
  logic [REG_W-1:0]        rf_waddr;
  logic [WORD_W-1:0]       rf_wdata;

  assign instr_op = instr_op_e'(instr_q[OPC_LSB +: 3]);
  assign ra_w     = instr_q[RA_LSB +: REG_W];
  assign rb_w     = instr_q[RB_LSB +: REG_W];
  assign rd_w     = instr_q[REG_W-1:0];
  assign off_ext  = {{(WOP_W-OFF_W){instr_q[OFF_W-1]}}, instr_q[OFF_W-1:0]};
  assign pc_next  = (pc_q == LAST_ADDR) ? '0 : pc_q + AW'(1);

  // address expression to wrap
  always_comb begin
    wrap_opd = WOP_W'(item_addr_q);
    if (item_op_q == ITEM_EXEC) begin
      case (instr_op) inside
        INSTR_LW, INSTR_SW: wrap_opd = {opa_q[WORD_W-1], opa_q} + off_ext;
        INSTR_BEQ:          wrap_opd = WOP_W'(pc_q) + WOP_W'(1) + off_ext;
        INSTR_JALR: begin
          // link write lands first, so regA == regB jumps to the link value
          wrap_opd = (ra_w == rb_w) ? WOP_W'(pc_next) : {1'b0, opa_q};
        end
        default:            wrap_opd = WOP_W'(item_addr_q);
      endcase
    end
  end

  lc2k_wrap #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_wrap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.wrap_start),
    .operand_i (wrap_opd),
    .done_o    (wrap_done),
    .result_o  (wrap_res)
  );

  // main memory, single port
  assign mem_addr  = cmd_i.mem_at_pc ? pc_q : wrap_res;
  assign mem_wdata = (item_op_q == ITEM_WRITE) ? item_data_q : opb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      mem_rdata_q <= mem_q[mem_addr];
    end
  end

  // register file: two combinational read ports, one write port
  assign rf_ra = cmd_i.load_item ? address_i[REG_W-1:0] : mem_rdata_q[RA_LSB +: REG_W];
  assign rf_rb = mem_rdata_q[RB_LSB +: REG_W];
  assign rf_a  = rf_valid_q[rf_ra] ? rf_q[rf_ra] : '0;
  assign rf_b  = rf_valid_q[rf_rb] ? rf_q[rf_rb] : '0;

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = rd_w;
    rf_wdata = '0;
    if (cmd_i.mem_wb && (item_op_q == ITEM_EXEC)) begin
      rf_we    = 1'b1;
      rf_waddr = rb_w;
      rf_wdata = mem_rdata_q;
    end else if (cmd_i.reg_wr) begin
      case (instr_op)
        INSTR_ADD: begin
          rf_we    = 1'b1;
          rf_wdata = opa_q + opb_q;
        end
        INSTR_NOR: begin
          rf_we    = 1'b1;
          rf_wdata = ~(opa_q | opb_q);
        end
        INSTR_JALR: begin
          rf_we    = 1'b1;
          rf_waddr = rb_w;
          rf_wdata = WORD_W'(pc_next);
        end
        default: rf_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_waddr] <= rf_wdata;
    end
  end

  // item capture, instruction latch and read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_op_q   <= opcode_i;
      item_addr_q <= address_i;
      item_data_q <= data_i;
      rdata_q     <= (opcode_i == ITEM_READ_REG) ? rf_a : '0;
    end else if (cmd_i.mem_wb && (item_op_q == ITEM_READ_MEM)) begin
      rdata_q <= mem_rdata_q;
    end
    if (cmd_i.instr_load) begin
      instr_q <= mem_rdata_q;
      opa_q   <= rf_a;
      opb_q   <= rf_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= '0;
      status_q   <= RUN_OK;
      count_q    <= '0;
      rf_valid_q <= '0;
    end else begin
      if (cmd_i.pc_wrap) begin
        pc_q <= wrap_res;
      end else if (cmd_i.pc_adv) begin
        pc_q <= pc_next;
      end
      if (cmd_i.set_halt) begin
        status_q <= RUN_HALTED;
      end else if (cmd_i.set_illegal) begin
        status_q <= RUN_ILLEGAL;
      end
      if (cmd_i.count_inc) begin
        count_q <= count_q + WORD_W'(1);
      end
      if (rf_we) begin
        rf_valid_q[rf_waddr] <= 1'b1;
      end
    end
  end

  assign status_o.item_op   = item_op_q;
  assign status_o.instr_op  = instr_op;
  assign status_o.stopped   = (status_q != RUN_OK);
  assign status_o.illegal   = |instr_q[WORD_W-1:ILL_LSB];
  assign status_o.equal     = (opa_q == opb_q);
  assign status_o.wrap_done = wrap_done;

  assign read_data_o       = rdata_q;
  assign program_counter_o = ITEM_ADDR_W'(pc_q);
  assign run_status_o      = status_q;
  assign executed_count_o  = count_q;

endmodule

// ===== src/lc2k_ctrl.sv =====
// ----------------------------------------------------------------------------
// lc2k_ctrl
// Multicycle sequencer for item handling and instruction execution.
// ----------------------------------------------------------------------------
module lc2k_ctrl import lc2k_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  item_op_e    opcode_i,
  input  dp_status_t  status_i,
  output dp_cmd_t     cmd_o,
  output logic        busy_o,
  output logic        done_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FETCH  = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_EXEC   = 9'b000001000,
    S_WSTART = 9'b000010000,
    S_WWAIT  = 9'b000100000,
    S_MEM    = 9'b001000000,
    S_MEMWB  = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   is_exec;
  logic   is_mem_read;

  assign is_exec     = (status_i.item_op == ITEM_EXEC);
  assign is_mem_read = (status_i.item_op == ITEM_READ_MEM) ||
                       (is_exec && (status_i.instr_op == INSTR_LW));

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          unique case (opcode_i)
            ITEM_WRITE, ITEM_READ_MEM: state_d = S_WSTART;
            ITEM_READ_REG:             state_d = S_RESP;
            ITEM_EXEC:                 state_d = status_i.stopped ? S_RESP : S_FETCH;
            default:                   state_d = S_RESP;
          endcase
        end
      end
      S_FETCH: begin
        cmd_o.mem_rd    = 1'b1;
        cmd_o.mem_at_pc = 1'b1;
        state_d         = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.instr_load = 1'b1;
        state_d          = S_EXEC;
      end
      S_EXEC: begin
        if (status_i.illegal) begin
          cmd_o.set_illegal = 1'b1;
          state_d           = S_RESP;
        end else begin
          cmd_o.count_inc = 1'b1;
          unique case (status_i.instr_op) inside
            INSTR_ADD, INSTR_NOR: begin
              cmd_o.reg_wr = 1'b1;
              cmd_o.pc_adv = 1'b1;
              state_d      = S_RESP;
            end
            INSTR_LW, INSTR_SW: state_d = S_WSTART;
            INSTR_BEQ: begin
              if (status_i.equal) begin
                state_d = S_WSTART;
              end else begin
                cmd_o.pc_adv = 1'b1;
                state_d      = S_RESP;
              end
            end
            INSTR_JALR: begin
              cmd_o.reg_wr = 1'b1;
              state_d      = S_WSTART;
            end
            INSTR_HALT: begin
              cmd_o.set_halt = 1'b1;
              cmd_o.pc_adv   = 1'b1;
              state_d        = S_RESP;
            end
            INSTR_NOOP: begin
              cmd_o.pc_adv = 1'b1;
              state_d      = S_RESP;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_WSTART: begin
        cmd_o.wrap_start = 1'b1;
        state_d          = S_WWAIT;
      end
      S_WWAIT: begin
        if (status_i.wrap_done) begin
          // branch and jump targets go to the pc, the rest to memory
          if (is_exec && (status_i.instr_op != INSTR_LW) &&
              (status_i.instr_op != INSTR_SW)) begin
            cmd_o.pc_wrap = 1'b1;
            state_d       = S_RESP;
          end else begin
            state_d = S_MEM;
          end
        end
      end
      S_MEM: begin
        if (is_mem_read) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = S_MEMWB;
        end else begin
          cmd_o.mem_wr = 1'b1;
          cmd_o.pc_adv = is_exec;
          state_d      = S_RESP;
        end
      end
      S_MEMWB: begin
        cmd_o.mem_wb = 1'b1;
        cmd_o.pc_adv = is_exec;
        state_d      = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

// ===== src/lc2k_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// lc2k_instruction_executor
// Eight-register, 32-bit multicycle teaching processor with a command port.
// Raise start with opcode_i/address_i/data_i while busy is low; the item is
// taken on that edge and busy rises the next cycle. Item codes: write a
// memory word, execute the instruction at the pc, read a memory word, read
// a register. Exactly one result follows per item: done_o is high for one
// cycle with read_data_o, program_counter_o, status_o and executed_count_o,
// and the receiver must take it then; it cannot stall. busy drops the cycle
// after done_o, and a start held high is taken at the end of that cycle.
// Every item leaves IDLE, runs through its own states and ends in RESP.
// A register read goes straight to RESP. Memory writes and reads wrap the
// address (WSTART, WWAIT), then use the memory (MEM, and MEMWB for a read).
// An execute item runs FETCH, DECODE and EXEC; lw, sw, taken beq and jalr
// then wrap an address, and lw and sw use the memory as above. The memory
// is single-ported; for depths that are not a power of two the wrap unit
// works 4 bits a cycle. Execute items on a stopped machine go straight to
// RESP. Reset clears pc, registers, status and the count; memory is
// undefined until written.
// ----------------------------------------------------------------------------
module lc2k_instruction_executor import lc2k_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode_i,
  input  logic [ITEM_ADDR_W-1:0]         address_i,
  input  logic signed [WORD_W-1:0]       data_i,
  output logic                           done_o,
  output logic signed [WORD_W-1:0]       read_data_o,
  output logic [ITEM_ADDR_W-1:0]         program_counter_o,
  output logic [1:0]                     status_o,
  output logic [WORD_W-1:0]              executed_count_o
);

  dp_cmd_t            cmd;
  dp_status_t         dp_status;
  run_status_e        run_status;
  logic [WORD_W-1:0]  read_data;
  logic               ctrl_busy;

  // sequencer: one item in flight, one transfer out per item
  lc2k_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (item_op_e'(opcode_i)),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (ctrl_busy),
    .done_o   (done_o)
  );

  // state, memory and address arithmetic
  lc2k_datapath #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .opcode_i          (item_op_e'(opcode_i)),
    .address_i         (address_i),
    .data_i            (data_i),
    .cmd_i             (cmd),
    .status_o          (dp_status),
    .read_data_o       (read_data),
    .program_counter_o (program_counter_o),
    .run_status_o      (run_status),
    .executed_count_o  (executed_count_o)
  );

  assign busy        = ctrl_busy;
  assign read_data_o = signed'(read_data);
  assign status_o    = run_status;

  // a transfer lasts a single cycle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // a stopped machine stays stopped
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_o != 2'(RUN_OK)) |=> (status_o == $past(status_o)))
    else $error("run status left its stopped value");

  // once stopped, pc and count hold
  a_stop_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_o != 2'(RUN_OK)) |=> ($stable(program_counter_o) && $stable(executed_count_o)))
    else $error("stopped machine changed pc or count");

  // count advances by at most one per cycle
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(executed_count_o) |-> (executed_count_o == $past(executed_count_o) + WORD_W'(1)))
    else $error("executed count jumped");

endmodule
